>>> rtl/core/maze_backtracker_step_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the maze backtracker step block
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MAZE_BACKTRACKER_STEP_TOP_DEFINES_SVH
`define MAZE_BACKTRACKER_STEP_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MBS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/mbs_pkg.sv
// ----------------------------------------------------------------------------
// Maze backtracker step package
// Sizes, codes, state type and small helper functions for the carving block.
// ----------------------------------------------------------------------------
package mbs_pkg;

   localparam int MAX_COLS    = 32;
   localparam int MAX_ROWS    = 32;
   localparam int RAND_BITS   = 16;

   localparam int COL_W       = $clog2(MAX_COLS);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int CELL_W      = ROW_W + COL_W;
   localparam int STACK_DEPTH = 1024;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int CNT_W       = STACK_AW + 1;

   localparam int CFG_W       = 6;
   localparam int CSR_IDX_W   = 1;
   localparam int RND_W       = 16;
   localparam int RND_USE_W   = (RAND_BITS < RND_W) ? RAND_BITS : RND_W;
   localparam int XY_W        = 5;
   localparam int STATUS_W    = 3;
   localparam int DIR_W       = 2;

   localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(26);
   localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(18);

   localparam logic [CSR_IDX_W-1:0] CSR_COLS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = CSR_IDX_W'(1);

   localparam logic CMD_CARVE   = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STS_CARVED       = 3'd0,
      STS_BACKTRACKED  = 3'd1,
      STS_JUST_DONE    = 3'd2,
      STS_ALREADY_DONE = 3'd3,
      STS_RESTARTED    = 3'd4
   } status_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_UP    = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW_MID,
      ST_ROW_UP,
      ST_DECIDE
   } state_type;

   // Residue modulo 3: even bits weigh 1, odd bits weigh 2, then fold twice.
   function automatic logic [1:0] rnd_mod3(input logic [RND_USE_W-1:0] r);
      logic [RND_USE_W-1:0] ev;
      logic [RND_USE_W-1:0] od;
      logic [7:0]           s;
      logic [3:0]           s2;
      logic [2:0]           s3;
      for (int i = 0; i < RND_USE_W; i++) begin
         ev[i] = ((i & 1) == 0) ? r[i] : 1'b0;
         od[i] = ((i & 1) == 0) ? 1'b0 : r[i];
      end
      s  = 8'($countones(ev)) + (8'($countones(od)) << 1);
      s2 = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]) + 4'(s[7:6]);
      s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
      if (s3 >= 3'd3) begin
         s3 = s3 - 3'd3;
      end
      if (s3 >= 3'd3) begin
         s3 = s3 - 3'd3;
      end
      return s3[1:0];
   endfunction

   // Direction of the k-th set bit of the free mask, counting up, right, down, left.
   function automatic dir_type pick_kth(input logic [3:0] free, input logic [1:0] k);
      dir_type    d_sel;
      logic [2:0] seen;
      d_sel = DIR_UP;
      seen  = 3'd0;
      for (int d = 0; d < 4; d++) begin
         if (free[d] && (seen == {1'b0, k})) begin
            d_sel = dir_type'(2'(d));
         end
         seen = seen + 3'(free[d]);
      end
      return d_sel;
   endfunction

endpackage

>>> rtl/core/mbs_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/maze_backtracker_step_top.sv
// ----------------------------------------------------------------------------
// Maze backtracker step - top level
// A carve, backtrack or completion step reads the current row, the row above and
//   the row below in turn through the single read port of the visited-map RAM,
//   then decides and registers its result; already-complete and restart answer
//   with a registered strobe straight from the accept. No step is taken while busy.
// Reset and restart both run a clearing pass over all MAX_ROWS rows (32) of the
//   visited map with busy high; the receiver cannot stall results.
// ----------------------------------------------------------------------------
`include "maze_backtracker_step_top_defines.svh"

module maze_backtracker_step_top
   import mbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // command transaction
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_cmd,
   input  logic [RND_W-1:0]     req_random_value,
   // result transaction
   output logic                 rsp_strobe,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [XY_W-1:0]      rsp_cell_x,
   output logic [XY_W-1:0]      rsp_cell_y,
   output logic [XY_W-1:0]      rsp_from_x,
   output logic [XY_W-1:0]      rsp_from_y,
   output logic [DIR_W-1:0]     rsp_carve_dir,
   // register write transaction
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [ROW_W-1:0]   clr_row_ff, clr_row_in;
   logic [COL_W-1:0]   pos_x_ff, pos_x_in;
   logic [ROW_W-1:0]   pos_y_ff, pos_y_in;
   logic [CNT_W-1:0]   stack_count_ff, stack_count_in;
   logic               finished_ff, finished_in;
   logic [CFG_W-1:0]   cols_cfg_ff, cols_cfg_in;
   logic [CFG_W-1:0]   rows_cfg_ff, rows_cfg_in;
   logic [1:0]         rnd_low_ff, rnd_low_in;
   logic [1:0]         rnd_mod3_ff, rnd_mod3_in;
   logic [MAX_COLS-1:0] row_mid_ff, row_mid_in;
   logic [MAX_COLS-1:0] row_up_ff, row_up_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [COL_W-1:0]   rsp_cell_x_ff, rsp_cell_x_in;
   logic [ROW_W-1:0]   rsp_cell_y_ff, rsp_cell_y_in;
   logic [COL_W-1:0]   rsp_from_x_ff, rsp_from_x_in;
   logic [ROW_W-1:0]   rsp_from_y_ff, rsp_from_y_in;
   dir_type            rsp_dir_ff, rsp_dir_in;

   // ------------------------------------------------------------------------
   // Memory ports
   // ------------------------------------------------------------------------
   logic                vis_wr_en;
   logic [ROW_W-1:0]    vis_wr_addr;
   logic [MAX_COLS-1:0] vis_wr_data;
   logic                vis_rd_en;
   logic [ROW_W-1:0]    vis_rd_addr;
   logic [MAX_COLS-1:0] vis_rd_data;

   logic                stk_wr_en;
   logic [STACK_AW-1:0] stk_wr_addr;
   logic [CELL_W-1:0]   stk_wr_data;
   logic                stk_rd_en;
   logic [STACK_AW-1:0] stk_rd_addr;
   logic [CELL_W-1:0]   stk_rd_data;

   // ------------------------------------------------------------------------
   // Decision path
   // ------------------------------------------------------------------------
   logic                accept;
   logic [COL_W:0]      cols_eff;
   logic [ROW_W:0]      rows_eff;
   logic [COL_W:0]      x_wide, x_p1, x_m1_wide;
   logic [ROW_W:0]      y_wide, y_p1, y_m1_wide;
   logic [COL_W-1:0]    x_m1;
   logic                in_x, in_y;
   logic [3:0]          free_mask;
   logic [2:0]          free_cnt;
   logic [1:0]          pick_k;
   dir_type             pick_dir;
   logic [COL_W-1:0]    tgt_x;
   logic [ROW_W-1:0]    tgt_y;
   logic [MAX_COLS-1:0] tgt_row;
   logic [MAX_COLS-1:0] tgt_row_set;
   logic                stack_room;

   // Visited map: one row of MAX_COLS bits per maze row.
   mbs_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_visited_ram (
      .clock   (clock),
      .wr_en   (vis_wr_en),
      .wr_addr (vis_wr_addr),
      .wr_data (vis_wr_data),
      .rd_en   (vis_rd_en),
      .rd_addr (vis_rd_addr),
      .rd_data (vis_rd_data)
   );

   // Path stack: each entry holds a cell as {y, x}.
   mbs_ram #(
      .WIDTH (CELL_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && (state_ff == ST_IDLE);
   // take register writes only between steps, never beside an accept
   assign csr_ready = !busy && !start;

   // Clamp the size registers into 2 .. MAX.
   always_comb begin
      if (cols_cfg_ff < CFG_W'(2)) begin
         cols_eff = (COL_W+1)'(2);
      end else if (int'(cols_cfg_ff) > MAX_COLS) begin
         cols_eff = (COL_W+1)'(MAX_COLS);
      end else begin
         cols_eff = (COL_W+1)'(cols_cfg_ff);
      end
      if (rows_cfg_ff < CFG_W'(2)) begin
         rows_eff = (ROW_W+1)'(2);
      end else if (int'(rows_cfg_ff) > MAX_ROWS) begin
         rows_eff = (ROW_W+1)'(MAX_ROWS);
      end else begin
         rows_eff = (ROW_W+1)'(rows_cfg_ff);
      end
   end

   // Neighbour test. Up comes from the row above, down straight off the RAM
   // port, left and right from the current row. The current cell itself may
   // lie outside the area in use, so every neighbour checks both bounds.
   assign x_wide    = {1'b0, pos_x_ff};
   assign y_wide    = {1'b0, pos_y_ff};
   assign x_p1      = x_wide + (COL_W+1)'(1);
   assign y_p1      = y_wide + (ROW_W+1)'(1);
   assign x_m1_wide = x_wide - (COL_W+1)'(1);
   assign y_m1_wide = y_wide - (ROW_W+1)'(1);
   assign x_m1      = pos_x_ff - COL_W'(1);
   assign in_x      = (x_wide < cols_eff);
   assign in_y      = (y_wide < rows_eff);

   assign free_mask[DIR_UP]    = (pos_y_ff != '0) && (y_m1_wide < rows_eff) && in_x
                                 && !row_up_ff[pos_x_ff];
   assign free_mask[DIR_RIGHT] = (x_p1 < cols_eff) && in_y
                                 && !row_mid_ff[x_p1[COL_W-1:0]];
   assign free_mask[DIR_DOWN]  = (y_p1 < rows_eff) && in_x && !vis_rd_data[pos_x_ff];
   assign free_mask[DIR_LEFT]  = (pos_x_ff != '0) && (x_m1_wide < cols_eff) && in_y
                                 && !row_mid_ff[x_m1];

   assign free_cnt   = 3'($countones(free_mask));
   assign stack_room = (stack_count_ff < CNT_W'(STACK_DEPTH));

   // Random pick: k = random mod count; the residue mod 3 was taken on accept.
   always_comb begin
      case (free_cnt)
         3'd2:    pick_k = {1'b0, rnd_low_ff[0]};
         3'd3:    pick_k = rnd_mod3_ff;
         3'd4:    pick_k = rnd_low_ff;
         default: pick_k = 2'd0;
      endcase
   end

   assign pick_dir = pick_kth(free_mask, pick_k);

   // Target cell and the row that holds it, ready for write-back.
   always_comb begin
      case (pick_dir)
         DIR_UP: begin
            tgt_x   = pos_x_ff;
            tgt_y   = pos_y_ff - ROW_W'(1);
            tgt_row = row_up_ff;
         end
         DIR_RIGHT: begin
            tgt_x   = x_p1[COL_W-1:0];
            tgt_y   = pos_y_ff;
            tgt_row = row_mid_ff;
         end
         DIR_DOWN: begin
            tgt_x   = pos_x_ff;
            tgt_y   = y_p1[ROW_W-1:0];
            tgt_row = vis_rd_data;
         end
         DIR_LEFT: begin
            tgt_x   = x_m1;
            tgt_y   = pos_y_ff;
            tgt_row = row_mid_ff;
         end
         default: begin
            tgt_x   = pos_x_ff;
            tgt_y   = pos_y_ff;
            tgt_row = row_mid_ff;
         end
      endcase
   end

   assign tgt_row_set = tgt_row | (MAX_COLS'(1) << tgt_x);

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_row_ff == ROW_W'(MAX_ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_RESTART) begin
                  state_in = ST_CLEAR;
               end else if (!finished_ff) begin
                  state_in = ST_ROW_MID;
               end
            end
         end
         ST_ROW_MID: state_in = ST_ROW_UP;
         ST_ROW_UP:  state_in = ST_DECIDE;
         ST_DECIDE:  state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Memory control per state
   // ------------------------------------------------------------------------
   always_comb begin
      vis_wr_en   = 1'b0;
      vis_wr_addr = clr_row_ff;
      vis_wr_data = '0;
      vis_rd_en   = 1'b0;
      vis_rd_addr = pos_y_ff;
      stk_wr_en   = 1'b0;
      stk_wr_addr = stack_count_ff[STACK_AW-1:0];
      stk_wr_data = {pos_y_ff, pos_x_ff};
      stk_rd_en   = 1'b0;
      stk_rd_addr = stack_count_ff[STACK_AW-1:0] - STACK_AW'(1);
      case (state_ff)
         ST_CLEAR: begin
            // sweep one row a cycle; row zero keeps cell zero visited
            vis_wr_en   = 1'b1;
            vis_wr_data = (clr_row_ff == '0) ? MAX_COLS'(1) : '0;
         end
         ST_IDLE: begin
            // fetch the current row and the stack top on every accept
            vis_rd_en = accept;
            stk_rd_en = accept;
         end
         ST_ROW_MID: begin
            vis_rd_en   = 1'b1;
            vis_rd_addr = pos_y_ff - ROW_W'(1);
         end
         ST_ROW_UP: begin
            vis_rd_en   = 1'b1;
            vis_rd_addr = pos_y_ff + ROW_W'(1);
         end
         ST_DECIDE: begin
            // on a carve, write back the target row and push the current cell unless the stack is full
            if (free_cnt != 3'd0) begin
               vis_wr_en   = 1'b1;
               vis_wr_addr = tgt_y;
               vis_wr_data = tgt_row_set;
               stk_wr_en   = stack_room;
            end
         end
         default: begin
            vis_wr_en = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath next values
   // ------------------------------------------------------------------------
   always_comb begin
      clr_row_in     = clr_row_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      stack_count_in = stack_count_ff;
      finished_in    = finished_ff;
      cols_cfg_in    = cols_cfg_ff;
      rows_cfg_in    = rows_cfg_ff;
      rnd_low_in     = rnd_low_ff;
      rnd_mod3_in    = rnd_mod3_ff;
      row_mid_in     = row_mid_ff;
      row_up_in      = row_up_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_cell_x_in  = rsp_cell_x_ff;
      rsp_cell_y_in  = rsp_cell_y_ff;
      rsp_from_x_in  = rsp_from_x_ff;
      rsp_from_y_in  = rsp_from_y_ff;
      rsp_dir_in     = rsp_dir_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_row_in = clr_row_ff + ROW_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               rnd_low_in    = req_random_value[1:0];
               rnd_mod3_in   = rnd_mod3(req_random_value[RND_USE_W-1:0]);
               rsp_from_x_in = pos_x_ff;
               rsp_from_y_in = pos_y_ff;
               rsp_dir_in    = DIR_UP;
               if (req_cmd == CMD_RESTART) begin
                  // answer at once, then sweep the map with busy held
                  pos_x_in       = '0;
                  pos_y_in       = '0;
                  stack_count_in = '0;
                  finished_in    = 1'b0;
                  clr_row_in     = '0;
                  rsp_strobe_in  = 1'b1;
                  rsp_status_in  = STS_RESTARTED;
                  rsp_cell_x_in  = '0;
                  rsp_cell_y_in  = '0;
               end else if (finished_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STS_ALREADY_DONE;
                  rsp_cell_x_in = pos_x_ff;
                  rsp_cell_y_in = pos_y_ff;
               end
            end
         end
         ST_ROW_MID: begin
            row_mid_in = vis_rd_data;
         end
         ST_ROW_UP: begin
            row_up_in = vis_rd_data;
         end
         ST_DECIDE: begin
            rsp_strobe_in = 1'b1;
            rsp_from_x_in = pos_x_ff;
            rsp_from_y_in = pos_y_ff;
            rsp_dir_in    = DIR_UP;
            if (free_cnt != 3'd0) begin
               // carve: move on, push unless the stack is full
               pos_x_in      = tgt_x;
               pos_y_in      = tgt_y;
               if (stack_room) begin
                  stack_count_in = stack_count_ff + CNT_W'(1);
               end
               rsp_status_in = STS_CARVED;
               rsp_cell_x_in = tgt_x;
               rsp_cell_y_in = tgt_y;
               rsp_dir_in    = pick_dir;
            end else if (stack_count_ff != '0) begin
               // backtrack to the cell on top of the stack
               stack_count_in = stack_count_ff - CNT_W'(1);
               pos_x_in       = stk_rd_data[COL_W-1:0];
               pos_y_in       = stk_rd_data[CELL_W-1:COL_W];
               rsp_status_in  = STS_BACKTRACKED;
               rsp_cell_x_in  = stk_rd_data[COL_W-1:0];
               rsp_cell_y_in  = stk_rd_data[CELL_W-1:COL_W];
            end else begin
               finished_in   = 1'b1;
               rsp_status_in = STS_JUST_DONE;
               rsp_cell_x_in = pos_x_ff;
               rsp_cell_y_in = pos_y_ff;
            end
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase

      // register writes land only while idle and no command is offered
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COLS: cols_cfg_in = csr_wdata;
            CSR_ROWS: rows_cfg_in = csr_wdata;
            default:  cols_cfg_in = cols_cfg_ff;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Register update: control state reset, payload free-running
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_row_ff     <= '0;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         stack_count_ff <= '0;
         finished_ff    <= 1'b0;
         cols_cfg_ff    <= COLS_RESET;
         rows_cfg_ff    <= ROWS_RESET;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_row_ff     <= clr_row_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         stack_count_ff <= stack_count_in;
         finished_ff    <= finished_in;
         cols_cfg_ff    <= cols_cfg_in;
         rows_cfg_ff    <= rows_cfg_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rnd_low_ff    <= rnd_low_in;
      rnd_mod3_ff   <= rnd_mod3_in;
      row_mid_ff    <= row_mid_in;
      row_up_ff     <= row_up_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cell_x_ff <= rsp_cell_x_in;
      rsp_cell_y_ff <= rsp_cell_y_in;
      rsp_from_x_ff <= rsp_from_x_in;
      rsp_from_y_ff <= rsp_from_y_in;
      rsp_dir_ff    <= rsp_dir_in;
   end

   // ------------------------------------------------------------------------
   // Result ports
   // ------------------------------------------------------------------------
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_cell_x    = XY_W'(rsp_cell_x_ff);
   assign rsp_cell_y    = XY_W'(rsp_cell_y_ff);
   assign rsp_from_x    = XY_W'(rsp_from_x_ff);
   assign rsp_from_y    = XY_W'(rsp_from_y_ff);
   assign rsp_carve_dir = rsp_dir_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `MBS_ASSERT_NEXT(a_decide_responds, state_ff == ST_DECIDE,
      rsp_strobe_ff && (state_ff == ST_IDLE), "decision cycle gave no result")
   `MBS_ASSERT_NEXT(a_restart_sweeps, accept && (req_cmd == CMD_RESTART),
      (state_ff == ST_CLEAR) && (clr_row_ff == '0) && rsp_strobe_ff
         && (rsp_status_ff == STS_RESTARTED),
      "restart did not start the map sweep")
   `MBS_ASSERT_NOW(a_done_stack_empty, finished_ff,
      stack_count_ff == '0, "generation finished with cells still stacked")
   `MBS_ASSERT_NEXT(a_push_counts,
      (state_ff == ST_DECIDE) && (free_cnt != 3'd0) && stack_room,
      stack_count_ff == $past(stack_count_ff) + CNT_W'(1),
      "carve did not push the stack")

endmodule

>>> bench/tb_maze_backtracker_step_top.sv
// ----------------------------------------------------------------------------
// Maze backtracker step - testbench
// Drives carve and restart commands into the carving block and checks each
// result against a cycle-free model of the depth-first carve: visited map,
// path stack, position and completion flag. The maze size registers are
// rewritten between phases, sometimes without a restart, so that the current
// cell can fall outside the area in use.
// ----------------------------------------------------------------------------
module tb_maze_backtracker_step_top
   import mbs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic             cmd;
      logic [RND_W-1:0] rnd;
   } carve_cmd_type;

   typedef struct {
      status_type      status;
      logic [XY_W-1:0] cell_x;
      logic [XY_W-1:0] cell_y;
      logic [XY_W-1:0] from_x;
      logic [XY_W-1:0] from_y;
      dir_type         dir;
   } carve_result_type;

   // Drive every input to a known level from time zero.
   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 start            = 1'b0;
   logic                 req_cmd          = CMD_CARVE;
   logic [RND_W-1:0]     req_random_value = '0;
   logic                 csr_valid        = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = CSR_COLS;
   logic [CFG_W-1:0]     csr_wdata        = '0;

   logic                 busy;
   logic                 rsp_strobe;
   logic [STATUS_W-1:0]  rsp_status;
   logic [XY_W-1:0]      rsp_cell_x;
   logic [XY_W-1:0]      rsp_cell_y;
   logic [XY_W-1:0]      rsp_from_x;
   logic [XY_W-1:0]      rsp_from_y;
   logic [DIR_W-1:0]     rsp_carve_dir;
   logic                 csr_ready;

   // Commands waiting for the driver, and results waiting for the monitor.
   carve_cmd_type    carve_cmd_q[$];
   carve_result_type carve_result_q[$];
   carve_result_type oldest_result;
   int               sender_idle_pct = 0;
   int               fail_count      = 0;
   logic             took_cmd;

   // Model of the carving state, kept in step with the block.
   logic [CFG_W-1:0]               cols_cfg = COLS_RESET;
   logic [CFG_W-1:0]               rows_cfg = ROWS_RESET;
   bit [MAX_COLS*MAX_ROWS-1:0]     visited;
   int                             path_stack[STACK_DEPTH];
   int                             depth;
   int                             pos_x;
   int                             pos_y;
   bit                             maze_done;

   maze_backtracker_step_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_random_value (req_random_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_cell_x       (rsp_cell_x),
      .rsp_cell_y       (rsp_cell_y),
      .rsp_from_x       (rsp_from_x),
      .rsp_from_y       (rsp_from_y),
      .rsp_carve_dir    (rsp_carve_dir),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 2 ns clock period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Effective size: below two counts as two, above the store counts as the store.
   function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
      if (v < 2) begin
         return 2;
      end
      if (v > maxv) begin
         return maxv;
      end
      return int'(v);
   endfunction

   // Empty the map apart from the origin, drop the path and go home.
   task automatic clear_maze();
      visited    = '0;
      visited[0] = 1'b1;
      depth      = 0;
      pos_x      = 0;
      pos_y      = 0;
      maze_done  = 1'b0;
   endtask

   // Apply one accepted command to the model and queue the result it must give.
   task automatic advance_maze(input logic cmd, input logic [RND_W-1:0] rnd);
      carve_result_type r;
      int               cols;
      int               rows;
      int               n;
      int               k;
      int               nx;
      int               ny;
      int               idx;
      int               opt_x[4];
      int               opt_y[4];
      dir_type          opt_d[4];
      bit               ok;
      cols     = clamp_dim(cols_cfg, MAX_COLS);
      rows     = clamp_dim(rows_cfg, MAX_ROWS);
      r.from_x = XY_W'(pos_x);
      r.from_y = XY_W'(pos_y);
      r.dir    = DIR_UP;
      if (cmd == CMD_RESTART) begin
         clear_maze();
         r.status = STS_RESTARTED;
      end else if (maze_done) begin
         r.status = STS_ALREADY_DONE;
      end else begin
         n = 0;
         // Gather free neighbours inside the area in use: up, right, down, left.
         for (int d = 0; d < 4; d++) begin
            nx = pos_x;
            ny = pos_y;
            case (dir_type'(d))
               DIR_UP: begin
                  ok = (pos_y > 0);
                  ny = pos_y - 1;
               end
               DIR_RIGHT: begin
                  ok = 1'b1;
                  nx = pos_x + 1;
               end
               DIR_DOWN: begin
                  ok = 1'b1;
                  ny = pos_y + 1;
               end
               default: begin
                  ok = (pos_x > 0);
                  nx = pos_x - 1;
               end
            endcase
            if (ok && nx < cols && ny < rows && !visited[ny*MAX_COLS + nx]) begin
               opt_x[n] = nx;
               opt_y[n] = ny;
               opt_d[n] = dir_type'(d);
               n++;
            end
         end
         if (n > 0) begin
            k = int'(rnd[RND_USE_W-1:0] % n);
            visited[opt_y[k]*MAX_COLS + opt_x[k]] = 1'b1;
            if (depth < STACK_DEPTH) begin
               path_stack[depth] = pos_y*MAX_COLS + pos_x;
               depth++;
            end
            pos_x    = opt_x[k];
            pos_y    = opt_y[k];
            r.dir    = opt_d[k];
            r.status = STS_CARVED;
         end else if (depth > 0) begin
            depth--;
            idx      = path_stack[depth] % (MAX_COLS*MAX_ROWS);
            pos_x    = idx % MAX_COLS;
            pos_y    = idx / MAX_COLS;
            r.status = STS_BACKTRACKED;
         end else begin
            maze_done = 1'b1;
            r.status  = STS_JUST_DONE;
         end
      end
      r.cell_x = XY_W'(pos_x);
      r.cell_y = XY_W'(pos_y);
      carve_result_q.insert(carve_result_q.size(), r);
   endtask

   task automatic push_cmd(input logic cmd, input logic [RND_W-1:0] rnd);
      carve_cmd_type c;
      c.cmd = cmd;
      c.rnd = rnd;
      carve_cmd_q.insert(carve_cmd_q.size(), c);
   endtask

   // Hold until every command has gone in, every result has come out and the
   // clearing pass after a restart has finished.
   task automatic wait_idle();
      while (carve_cmd_q.size() != 0 || carve_result_q.size() != 0 || start || busy) begin
         @(posedge clock);
      end
   endtask

   // One register write transaction; the model takes the value at the handshake.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= CFG_W'(value);
      do begin
         @(posedge clock);
      end while (!csr_ready);
      if (index == CSR_COLS) begin
         cols_cfg = CFG_W'(value);
      end else begin
         rows_cfg = CFG_W'(value);
      end
      csr_valid <= 1'b0;
   endtask

   // One phase: resize while idle, optionally restart, then random carving.
   // Random content with the odd stray restart thrown in as noise.
   task automatic run_phase(input int cols, input int rows, input bit fresh,
                            input int n_cmds, input int idle_pct);
      wait_idle();
      write_reg(CSR_COLS, cols);
      write_reg(CSR_ROWS, rows);
      sender_idle_pct = idle_pct;
      if (fresh) begin
         push_cmd(CMD_RESTART, RND_W'($urandom_range(0, 65535)));
      end
      repeat (n_cmds) begin
         push_cmd(($urandom_range(0, 99) < 2) ? CMD_RESTART : CMD_CARVE,
                  RND_W'($urandom_range(0, 65535)));
      end
   endtask

   // Driver: take the front command at the accepting edge, then decide whether
   // to present the next one or leave a gap. Start stays high until accepted.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         took_cmd = start && !busy;
         if (took_cmd) begin
            advance_maze(req_cmd, req_random_value);
            carve_cmd_q.delete(0);
         end
         if (took_cmd || !start) begin
            if (carve_cmd_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               start            <= 1'b1;
               req_cmd          <= carve_cmd_q[0].cmd;
               req_random_value <= carve_cmd_q[0].rnd;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Monitor: every strobe must match the oldest outstanding expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (carve_result_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d",
                     $time, rsp_status);
            fail_count++;
         end else begin
            oldest_result = carve_result_q[0];
            carve_result_q.delete(0);
            check_field("status", 8'(oldest_result.status), 8'(rsp_status));
            check_field("cell_x", 8'(oldest_result.cell_x), 8'(rsp_cell_x));
            check_field("cell_y", 8'(oldest_result.cell_y), 8'(rsp_cell_y));
            check_field("from_x", 8'(oldest_result.from_x), 8'(rsp_from_x));
            check_field("from_y", 8'(oldest_result.from_y), 8'(rsp_from_y));
            check_field("carve_dir", 8'(oldest_result.dir), 8'(rsp_carve_dir));
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         path_stack[i] = 0;
      end
      clear_maze();
      // Hold reset at the start of the run, once only.
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme random values at the default size, restart with a
      // stray random value, then a full 2x2 maze from register values below
      // the minimum, through completion and beyond it.
      push_cmd(CMD_CARVE, 16'd0);
      push_cmd(CMD_CARVE, 16'hFFFF);
      push_cmd(CMD_CARVE, 16'd1);
      push_cmd(CMD_CARVE, 16'd2);
      push_cmd(CMD_CARVE, 16'd3);
      push_cmd(CMD_RESTART, 16'hFFFF);
      push_cmd(CMD_RESTART, 16'd0);
      wait_idle();
      write_reg(CSR_COLS, 0);
      write_reg(CSR_ROWS, 1);
      push_cmd(CMD_RESTART, 16'h5A5A);
      push_cmd(CMD_CARVE, 16'hFFFF);
      push_cmd(CMD_CARVE, 16'd0);
      push_cmd(CMD_CARVE, 16'h8001);
      push_cmd(CMD_CARVE, 16'd7);
      push_cmd(CMD_CARVE, 16'hFFFF);
      push_cmd(CMD_CARVE, 16'd0);
      push_cmd(CMD_CARVE, 16'h1234);
      push_cmd(CMD_CARVE, 16'hFFFF);
      push_cmd(CMD_CARVE, 16'd0);
      push_cmd(CMD_RESTART, 16'd0);

      // Random phases: small mazes run to completion, a tall one at the
      // register maximum, mid-carve resizes without a restart (the current
      // cell may then sit outside the area) and a full-store maze.
      run_phase(2, 3, 1'b1, 24, 0);
      run_phase(4, 4, 1'b1, 45, 61);
      run_phase(1, 63, 1'b1, 130, 11);
      run_phase(3, 2, 1'b0, 40, 0);
      run_phase(40, 32, 1'b1, 40, 61);
      run_phase(5, 5, 1'b0, 40, 11);
      run_phase(32, 0, 1'b1, 60, 0);
      run_phase($urandom_range(2, 8), $urandom_range(2, 8), 1'b1, 60, 61);

      // Drain, then wait on for any stray strobe.
      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_maze_backtracker_step_top OK");
      end else begin
         $display("tb_maze_backtracker_step_top NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #1_000_000;
      $display("tb_maze_backtracker_step_top NOT OK");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mbs_pkg.sv
rtl/core/mbs_ram.sv
rtl/core/maze_backtracker_step_top.sv
bench/tb_maze_backtracker_step_top.sv
